@@ hdl/glos_pkg.sv @@
// Package: shared constants and types for the grid line-of-sight block.
`timescale 1ns / 1ps
`default_nettype none
package glos_pkg;
  localparam int MAP_WIDTH_DEF  = 32;
  localparam int MAP_HEIGHT_DEF = 32;
  localparam int FRAC_BITS_DEF  = 11;
  localparam int DIR_FRAC       = 14;
  localparam int DIST_W         = 32;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIVX, ST_DIVY, ST_MULX, ST_MULY, ST_STEP, ST_READ, ST_CHECK, ST_OUT
  } walk_state_t;
endpackage
`default_nettype wire

@@ hdl/glos_div.sv @@
// Restoring divider, one quotient bit per cycle: 2^(14+F) / mag.
`timescale 1ns / 1ps
`default_nettype none
module glos_div #(
  parameter int FRAC_BITS = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [16:0]               mag,
  output logic                           done,
  output logic [glos_pkg::DIST_W-1:0]    quot
);
  import glos_pkg::*;
  localparam int NB = DIR_FRAC + FRAC_BITS + 1;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0]  dvd_r, dvd_nxt;
  logic [17:0]    rem_r, rem_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic [17:0]    trial;
  logic [18:0]    sub;
  logic [NB-1:0]  qsh;

  always_comb begin
    dvd_nxt = dvd_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r[16:0], dvd_r[NB-1]};
    sub = {1'b0, trial} - {2'b0, mag};
    qsh = {dvd_r[NB-2:0], !sub[18]};
    if (start) begin
      dvd_nxt = NB'(1) << (NB - 1);
      rem_nxt = '0;
      cnt_nxt = CW'(NB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = sub[18] ? trial : sub[17:0];
      dvd_nxt = qsh;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1)) ;
  // quotient fits in 15+F bits (26 by default); final bit enters on the done cycle
  assign quot = DIST_W'(qsh);
endmodule
`default_nettype wire

@@ hdl/grid_line_of_sight_top.sv @@
// Top level: tile map memory and DDA ray walker.
// Usage:
//  - Input beats on in_*: kind 0 writes one map cell (no result), kind 1 runs a
//    line-of-sight query that returns exactly one out_* beat with blocked.
//  - A map write is taken as a single beat; the block stays ready for the next beat.
//  - A query first runs two serial divisions of 15+F quotient bits each (one
//    quotient bit per cycle, F = FRAC_BITS), then one side-distance product
//    per axis, then walks the grid cell by cell: step, map read (registered
//    memory), check; a solid cell in the map ends the walk at check, a final
//    step ends a walk that runs out of length, then the result is offered.
//  - One item is worked at a time; in_tready is low while an item is in work.
//  - A finished result sits in the out_ register until taken; in_tready rises
//    again the cycle after the result is handed over.
//  - Reset: a clearing pass writes every map cell empty, one per cycle;
//    in_tready stays low until the pass ends.
//  - A stalled receiver holds the block in the output state; nothing is lost.
//  - Cells outside the map read as empty; writes outside the map are dropped.
`timescale 1ns / 1ps
`default_nettype none
module grid_line_of_sight_top #(
  parameter int MAP_WIDTH  = glos_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = glos_pkg::MAP_HEIGHT_DEF,
  parameter int FRAC_BITS  = glos_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: cell_x[4:0], cell_y[9:5], cell_solid[10], origin_x[26:11],
  // origin_y[42:27], dir_x[58:43], dir_y[74:59], max_length[91:75]
  input  wire logic [95:0]  in_tdata,
  input  wire logic         in_tuser,   // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata   // blocked[0]
);
  import glos_pkg::*;
  localparam int XW = $clog2(MAP_WIDTH);
  localparam int YW = $clog2(MAP_HEIGHT);
  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = 18;   // signed cell coordinate
  localparam int PW = FRAC_BITS + 1;

  logic [4:0]  f_cx, f_cy;
  logic        f_solid;
  logic [15:0] f_ox, f_oy, f_dx, f_dy;
  logic [16:0] f_len;
  assign f_cx = in_tdata[4:0];
  assign f_cy = in_tdata[9:5];
  assign f_solid = in_tdata[10];
  assign f_ox = in_tdata[26:11];
  assign f_oy = in_tdata[42:27];
  assign f_dx = in_tdata[58:43];
  assign f_dy = in_tdata[74:59];
  assign f_len = in_tdata[91:75];

  // map memory
  logic mem [DEPTH];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic          wdat, rdat_r;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdat;
    rdat_r <= mem[raddr];
  end

  walk_state_t st_r, st_nxt;
  logic              clr_r;
  logic [AW:0]       ccnt_r;
  logic [CW-1:0]     mx_r, my_r;
  logic              nx_r, ny_r, zx_r, zy_r;
  logic [PW-1:0]     px_r, py_r;
  logic [16:0]       len_r;
  logic [DIST_W-1:0] dx_r, dy_r, sx_r, sy_r, dist_r;
  logic              blk_r, outv_r;
  logic [16:0]       xmag_r, ymag_r;
  logic              inmap;

  // division unit shared by the two axes
  logic        dstart, ddone;
  logic [16:0] dmag;
  logic [DIST_W-1:0] dq;
  glos_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .mag(dmag), .done(ddone), .quot(dq));

  function automatic logic [16:0] mag_of(input logic [15:0] d);
    return d[15] ? 17'h10000 - {1'b0, d} : {1'b0, d};
  endfunction

  logic acc;
  assign in_tready = (st_r == ST_IDLE) && !clr_r;
  assign acc = in_tvalid && in_tready;

  assign inmap = !mx_r[CW-1] && !my_r[CW-1] &&
                 (mx_r < CW'(MAP_WIDTH)) && (my_r < CW'(MAP_HEIGHT));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (acc && in_tuser) st_nxt = ST_DIVX;
      ST_DIVX:  if (ddone) st_nxt = ST_DIVY;
      ST_DIVY:  if (ddone) st_nxt = ST_MULX;
      ST_MULX:  st_nxt = ST_MULY;
      ST_MULY:  st_nxt = ST_STEP;
      ST_STEP:  st_nxt = ({15'b0, len_r} > dist_r) ? ST_READ : ST_OUT;
      ST_READ:  st_nxt = ST_CHECK;
      ST_CHECK: st_nxt = ST_STEP;
      ST_OUT:   if (out_tready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_CHECK && rdat_r && inmap) st_nxt = ST_OUT;
  end

  logic [DIST_W:0] sumx, sumy;
  logic [DIST_W+PW-1:0] prod;
  assign sumx = {1'b0, sx_r} + {1'b0, dx_r};
  assign sumy = {1'b0, sy_r} + {1'b0, dy_r};
  assign prod = (st_r == ST_MULX) ? px_r * dx_r : py_r * dy_r;

  // divider held on the x magnitude through DIVX, then on y
  always_comb begin
    dstart = (acc && in_tuser) || (st_r == ST_DIVX && ddone);
    dmag = (st_r == ST_DIVX) ? xmag_r : ymag_r;
  end

  always_comb begin
    we = 1'b0;
    waddr = AW'(f_cy) * AW'(MAP_WIDTH) + AW'(f_cx);
    wdat = f_solid;
    if (clr_r) begin
      we = 1'b1; waddr = ccnt_r[AW-1:0]; wdat = 1'b0;
    end else if (acc && !in_tuser && 32'(f_cx) < MAP_WIDTH && 32'(f_cy) < MAP_HEIGHT)
      we = 1'b1;
    raddr = AW'(my_r[YW-1:0]) * AW'(MAP_WIDTH) + AW'(mx_r[XW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      clr_r <= 1'b1;
      ccnt_r <= '0;
      outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (clr_r) begin
        ccnt_r <= ccnt_r + 1'b1;
        if (ccnt_r == (AW+1)'(DEPTH - 1)) clr_r <= 1'b0;
      end
      outv_r <= (st_nxt == ST_OUT);
    end
    if (acc && in_tuser) begin
      nx_r <= f_dx[15]; ny_r <= f_dy[15];
      zx_r <= (f_dx == 16'd0); zy_r <= (f_dy == 16'd0);
      mx_r <= CW'(f_ox >> FRAC_BITS);
      my_r <= CW'(f_oy >> FRAC_BITS);
      px_r <= f_dx[15] ? PW'(f_ox[FRAC_BITS-1:0])
                       : (PW'(1) << FRAC_BITS) - PW'(f_ox[FRAC_BITS-1:0]);
      py_r <= f_dy[15] ? PW'(f_oy[FRAC_BITS-1:0])
                       : (PW'(1) << FRAC_BITS) - PW'(f_oy[FRAC_BITS-1:0]);
      len_r <= f_len;
      xmag_r <= mag_of(f_dx);
      ymag_r <= mag_of(f_dy);
      dist_r <= '0;
      blk_r <= 1'b0;
    end
    if (st_r == ST_DIVX && ddone) dx_r <= zx_r ? DIST_MAX : dq;
    if (st_r == ST_DIVY && ddone) dy_r <= zy_r ? DIST_MAX : dq;
    if (st_r == ST_MULX)
      sx_r <= zx_r ? DIST_MAX : DIST_W'(prod >> FRAC_BITS);
    if (st_r == ST_MULY)
      sy_r <= zy_r ? DIST_MAX : DIST_W'(prod >> FRAC_BITS);
    if (st_r == ST_STEP && st_nxt == ST_READ) begin
      if (sx_r < sy_r) begin
        dist_r <= sx_r;
        sx_r <= sumx[DIST_W] ? DIST_MAX : sumx[DIST_W-1:0];
        mx_r <= nx_r ? mx_r - 1'b1 : mx_r + 1'b1;
      end else begin
        dist_r <= sy_r;
        sy_r <= sumy[DIST_W] ? DIST_MAX : sumy[DIST_W-1:0];
        my_r <= ny_r ? my_r - 1'b1 : my_r + 1'b1;
      end
    end
    if (st_r == ST_CHECK && rdat_r && inmap)
      blk_r <= ({15'b0, len_r} > dist_r);
  end

  assign out_tvalid = outv_r;
  assign out_tdata = {7'b0, blk_r};
endmodule
`default_nettype wire

@@ hdl/glos_checker.sv @@
// Checker: port-level properties of the line-of-sight block, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module glos_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0) else $error("padding not zero");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("query accepted but block still ready");
endmodule

bind grid_line_of_sight_top glos_checker u_glos_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata));
`default_nettype wire
